FILE: sv/mlv_pkg.sv
// ----------------------------------------------------------------------------
// mlv_pkg
// Shared op codes, hash constant and inter-module types for the Maglev
// lookup table scheduler.
// ----------------------------------------------------------------------------
package mlv_pkg;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_REBUILD = 2'd1;
  localparam logic [1:0] OP_LOOKUP  = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  // multiplicative hash, product kept mod 2^32
  localparam logic [31:0] HASH_MULT = 32'h61C8_8647;

  // one queued word, front to back
  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  slot;
    logic [31:0] addr;
    logic [15:0] port;
    logic [15:0] weight;
    logic        overloaded;
  } mlv_item_t;

  // back to front status
  typedef struct packed {
    logic init_busy;   // post-reset table clear in progress
  } mlv_status_t;

endpackage

FILE: sv/mlv_modr.sv
// ----------------------------------------------------------------------------
// mlv_modr
// Remainder by a constant: reciprocal multiply, back-multiply and one
// correcting subtract, four registered steps from start to done.
// ----------------------------------------------------------------------------
module mlv_modr #(
  parameter int DW = 32,
  parameter int MW = 17,
  parameter int D  = 65537
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  output logic          done,
  output logic [MW-1:0] rem
);

  // quotient estimate floor(x * RECIP / 2^SH) is at most one below the true
  // quotient, so the first remainder is below 2*D
  localparam int          L     = $clog2(D);
  localparam int          SH    = DW + L;
  localparam int          RW    = DW + 1;
  localparam logic [63:0] RECIP = (64'd1 << SH) / 64'(D);

  logic [DW-1:0]    x_r, x_nxt;
  logic [DW+RW-1:0] prod_r, prod_nxt;
  logic [DW-1:0]    part_r, part_nxt;
  logic [MW-1:0]    rem_r, rem_nxt;
  logic             s1_r, s2_r, s3_r, done_r;
  logic [DW-1:0]    quo;

  assign quo = DW'(prod_r >> SH);

  always_comb begin
    x_nxt    = start ? dividend : x_r;
    prod_nxt = (DW+RW)'(x_r) * (DW+RW)'(RECIP[RW-1:0]);
    part_nxt = x_r - DW'(quo * DW'(D));
    rem_nxt  = (part_r >= DW'(D)) ? MW'(part_r - DW'(D)) : MW'(part_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= 1'b0;
      s2_r   <= 1'b0;
      s3_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= start;
      s2_r   <= s1_r;
      s3_r   <= s2_r;
      done_r <= s3_r;
    end
    x_r    <= x_nxt;
    prod_r <= prod_nxt;
    part_r <= part_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

FILE: sv/mlv_front.sv
// ----------------------------------------------------------------------------
// mlv_front
// Input side: accepts words, drops unused op codes, two-entry queue to back.
// ----------------------------------------------------------------------------
module mlv_front import mlv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [5:0]  in_slot,
  input  logic [31:0] in_addr,
  input  logic [15:0] in_port,
  input  logic [15:0] in_weight,
  input  logic        in_overloaded,
  input  mlv_status_t st,
  output logic        q_valid,
  output mlv_item_t   q_item,
  input  logic        q_pop
);

  mlv_item_t  fifo_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_stall = (cnt_r == 2'd2) || st.init_busy;
  assign push     = in_valid && !in_stall && (in_op != OP_NONE);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = fifo_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      fifo_r[wp_r] <= '{op: in_op, slot: in_slot, addr: in_addr, port: in_port,
                        weight: in_weight, overloaded: in_overloaded};
    end
  end

endmodule

FILE: sv/mlv_back.sv
// ----------------------------------------------------------------------------
// mlv_back
// Execution side: backend store, lookup table, rebuild sequencer, hash unit
// and the result register.
// ----------------------------------------------------------------------------
module mlv_back import mlv_pkg::*; #(
  parameter int TABLE_SIZE   = 65537,
  parameter int MAX_BACKENDS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [6:0]  dest_count,
  input  logic        q_valid,
  input  mlv_item_t   q_item,
  output logic        q_pop,
  output mlv_status_t st,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_op_done,
  output logic        out_found,
  output logic [5:0]  out_backend,
  output logic        out_table_empty
);

  localparam int SW   = (MAX_BACKENDS > 1) ? $clog2(MAX_BACKENDS) : 1;
  localparam int CNTW = $clog2(MAX_BACKENDS + 1);
  localparam int TIW  = $clog2(TABLE_SIZE);
  localparam int TCW  = $clog2(TABLE_SIZE + 1);
  localparam int TW   = SW + 1;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_KRD  = 14'b00000000000010,
    S_HASH = 14'b00000000000100,
    S_MODS = 14'b00000000001000,
    S_MODW = 14'b00000000010000,
    S_CLR  = 14'b00000000100000,
    S_FRD  = 14'b00000001000000,
    S_FCHK = 14'b00000010000000,
    S_PRB  = 14'b00000100000000,
    S_PCHK = 14'b00001000000000,
    S_LRD  = 14'b00010000000000,
    S_LCHK = 14'b00100000000000,
    S_LOV  = 14'b01000000000000,
    S_SPARE = 14'b10000000000000
  } state_t;

  // memories
  logic [31:0]  key_m [MAX_BACKENDS];
  logic [15:0]  wt_m  [MAX_BACKENDS];
  logic         ov_m  [MAX_BACKENDS];
  logic [TIW-1:0] pos_m [MAX_BACKENDS];
  logic [TIW-1:0] str_m [MAX_BACKENDS];
  logic [TW-1:0]  tbl_m [TABLE_SIZE];

  logic [31:0]    key_q;
  logic [15:0]    wt_q;
  logic           ov_q;
  logic [TIW-1:0] pos_q, str_q;
  logic [TW-1:0]  tbl_q;

  state_t         state_r, state_nxt;
  logic           init_r, init_nxt;
  logic           lk_r, lk_nxt;
  logic           sec_r, sec_nxt;
  logic           any_r, any_nxt;
  logic [1:0]     op_r, op_nxt;
  logic [SW-1:0]  i_r, i_nxt;
  logic [15:0]    run_r, run_nxt;
  logic [15:0]    w_r, w_nxt;
  logic [TCW-1:0] n_r, n_nxt;
  logic [TCW-1:0] k_r, k_nxt;
  logic [TIW-1:0] cur_r, cur_nxt;
  logic [TIW-1:0] stride_r, stride_nxt;
  logic [TIW-1:0] clr_r, clr_nxt;
  logic [TIW-1:0] ptmp_r, ptmp_nxt;
  logic [31:0]    lkey_r, lkey_nxt;
  logic [31:0]    mul_r, mul_nxt;
  logic [SW-1:0]  own_r, own_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic [1:0]     out_op_r, out_op_nxt;
  logic           out_found_r, out_found_nxt;
  logic [5:0]     out_be_r, out_be_nxt;
  logic           out_empty_r, out_empty_nxt;

  // memory write and read controls
  logic           bk_we;
  logic [SW-1:0]  bk_wa;
  logic           pos_we, str_we;
  logic [TIW-1:0] pos_wd, str_wd;
  logic           tbl_we;
  logic [TIW-1:0] tbl_wa, tbl_ra;
  logic [TW-1:0]  tbl_wd;
  logic [SW-1:0]  bk_ra;

  // hash and modulo
  logic           mod_start, mod_done;
  logic           done_tab, done_str;
  logic [TCW-1:0] mod_rem, rem_tab, rem_str;
  logic [31:0]    hkey;

  // helpers
  logic [CNTW-1:0] cnt_eff;
  logic            i_last;
  logic [SW-1:0]   i_next;
  logic [TIW:0]    psum;
  logic [TIW-1:0]  pos_adv;
  logic            fin, fin_found, fin_empty;
  logic [5:0]      fin_be;

  assign cnt_eff = (32'(dest_count) > MAX_BACKENDS) ? CNTW'(MAX_BACKENDS)
                                                     : CNTW'(dest_count);
  assign i_last  = (32'(i_r) + 32'd1) == 32'(cnt_eff);
  assign i_next  = i_last ? '0 : i_r + SW'(1);
  assign psum    = {1'b0, cur_r} + {1'b0, stride_r};
  assign pos_adv = (psum >= (TIW+1)'(TABLE_SIZE)) ? TIW'(psum - (TIW+1)'(TABLE_SIZE))
                                                   : TIW'(psum);

  assign hkey      = lk_r ? lkey_r : (sec_r ? key_q + 32'd1 : key_q);
  assign mod_start = (state_r == S_MODS);
  assign mod_done  = done_tab && done_str;
  assign mod_rem   = (lk_r || !sec_r) ? rem_tab : rem_str;
  assign tbl_ra    = (state_r == S_LRD) ? TIW'(mod_rem) : cur_r;
  assign bk_ra     = (state_r == S_LCHK) ? tbl_q[SW-1:0] : i_r;

  // bucket index: remainder by the table size
  mlv_modr #(.DW(32), .MW(TCW), .D(TABLE_SIZE)) u_mod_tab (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mul_r),
    .done     (done_tab),
    .rem      (rem_tab)
  );

  // stride: remainder by the table size less one
  mlv_modr #(.DW(32), .MW(TCW), .D(TABLE_SIZE - 1)) u_mod_str (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mul_r),
    .done     (done_str),
    .rem      (rem_str)
  );

  always_comb begin
    state_nxt  = state_r;
    init_nxt   = init_r;
    lk_nxt     = lk_r;
    sec_nxt    = sec_r;
    any_nxt    = any_r;
    op_nxt     = op_r;
    i_nxt      = i_r;
    run_nxt    = run_r;
    w_nxt      = w_r;
    n_nxt      = n_r;
    k_nxt      = k_r;
    cur_nxt    = cur_r;
    stride_nxt = stride_r;
    clr_nxt    = clr_r;
    ptmp_nxt   = ptmp_r;
    lkey_nxt   = lkey_r;
    mul_nxt    = mul_r;
    own_nxt    = own_r;
    q_pop      = 1'b0;
    bk_we      = 1'b0;
    bk_wa      = SW'(q_item.slot);
    pos_we     = 1'b0;
    pos_wd     = pos_adv;
    str_we     = 1'b0;
    str_wd     = TIW'(mod_rem) + TIW'(1);
    tbl_we     = 1'b0;
    tbl_wa     = cur_r;
    tbl_wd     = {1'b1, i_r};
    fin        = 1'b0;
    fin_found  = 1'b0;
    fin_be     = 6'd0;
    fin_empty  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid && (!out_valid_r || !out_stall)) begin
          q_pop  = 1'b1;
          op_nxt = q_item.op;
          unique case (q_item.op)
            OP_LOAD: begin
              bk_we = (32'(q_item.slot) < MAX_BACKENDS);
              fin   = 1'b1;
            end
            OP_REBUILD: begin
              lk_nxt  = 1'b0;
              sec_nxt = 1'b0;
              any_nxt = 1'b0;
              i_nxt   = '0;
              if (cnt_eff == '0) begin
                clr_nxt   = '0;
                state_nxt = S_CLR;
              end else begin
                state_nxt = S_KRD;
              end
            end
            OP_LOOKUP: begin
              lk_nxt    = 1'b1;
              lkey_nxt  = q_item.addr + {16'd0, q_item.port};
              state_nxt = S_HASH;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_KRD: begin
        state_nxt = S_HASH;
      end
      S_HASH: begin
        mul_nxt = hkey * HASH_MULT;
        if (!lk_r && !sec_r && (wt_q != 16'd0)) begin
          any_nxt = 1'b1;
        end
        state_nxt = S_MODS;
      end
      S_MODS: begin
        state_nxt = S_MODW;
      end
      S_MODW: begin
        if (mod_done) begin
          if (lk_r) begin
            state_nxt = S_LRD;
          end else if (!sec_r) begin
            ptmp_nxt  = TIW'(mod_rem);
            sec_nxt   = 1'b1;
            state_nxt = S_HASH;
          end else begin
            pos_we  = 1'b1;
            pos_wd  = ptmp_r;
            str_we  = 1'b1;
            sec_nxt = 1'b0;
            if (i_last) begin
              clr_nxt   = '0;
              state_nxt = S_CLR;
            end else begin
              i_nxt     = i_r + SW'(1);
              state_nxt = S_KRD;
            end
          end
        end
      end
      S_CLR: begin
        tbl_we = 1'b1;
        tbl_wa = clr_r;
        tbl_wd = '0;
        if (32'(clr_r) == TABLE_SIZE - 1) begin
          if (init_r) begin
            init_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end else if (!any_r) begin
            fin       = 1'b1;
            fin_empty = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = '0;
            run_nxt   = '0;
            n_nxt     = '0;
            state_nxt = S_FRD;
          end
        end else begin
          clr_nxt = clr_r + TIW'(1);
        end
      end
      S_FRD: begin
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (wt_q == 16'd0) begin
          run_nxt   = '0;
          i_nxt     = i_next;
          state_nxt = S_FRD;
        end else begin
          w_nxt      = wt_q;
          cur_nxt    = pos_q;
          stride_nxt = str_q;
          k_nxt      = '0;
          state_nxt  = S_PRB;
        end
      end
      S_PRB: begin
        state_nxt = S_PCHK;
      end
      S_PCHK: begin
        cur_nxt = pos_adv;
        if (!tbl_q[TW-1]) begin
          tbl_we = 1'b1;
          k_nxt  = '0;
          n_nxt  = n_r + TCW'(1);
          if (32'(n_r) + 32'd1 == TABLE_SIZE) begin
            fin       = 1'b1;
            state_nxt = S_IDLE;
          end else if ({1'b0, run_r} + 17'd1 >= {1'b0, w_r}) begin
            run_nxt   = '0;
            pos_we    = 1'b1;
            i_nxt     = i_next;
            state_nxt = S_FRD;
          end else begin
            run_nxt   = run_r + 16'd1;
            state_nxt = S_PRB;
          end
        end else if (32'(k_r) + 32'd1 == TABLE_SIZE) begin
          // permutation exhausted: leave the rest empty
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          k_nxt     = k_r + TCW'(1);
          state_nxt = S_PRB;
        end
      end
      S_LRD: begin
        state_nxt = S_LCHK;
      end
      S_LCHK: begin
        own_nxt = tbl_q[SW-1:0];
        if (tbl_q[TW-1]) begin
          state_nxt = S_LOV;
        end else begin
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_LOV: begin
        fin       = 1'b1;
        fin_found = !ov_q;
        fin_be    = ov_q ? 6'd0 : 6'(own_r);
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = fin ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
    out_op_nxt    = fin ? op_r : out_op_r;
    out_found_nxt = fin ? fin_found : out_found_r;
    out_be_nxt    = fin ? fin_be : out_be_r;
    out_empty_nxt = fin ? fin_empty : out_empty_r;
    if (fin && (state_r == S_IDLE)) begin
      out_op_nxt = q_item.op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      init_r      <= 1'b1;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lk_r        <= lk_nxt;
    sec_r       <= sec_nxt;
    any_r       <= any_nxt;
    op_r        <= op_nxt;
    i_r         <= i_nxt;
    run_r       <= run_nxt;
    w_r         <= w_nxt;
    n_r         <= n_nxt;
    k_r         <= k_nxt;
    cur_r       <= cur_nxt;
    stride_r    <= stride_nxt;
    ptmp_r      <= ptmp_nxt;
    lkey_r      <= lkey_nxt;
    mul_r       <= mul_nxt;
    own_r       <= own_nxt;
    out_op_r    <= out_op_nxt;
    out_found_r <= out_found_nxt;
    out_be_r    <= out_be_nxt;
    out_empty_r <= out_empty_nxt;
  end

  // backend store
  always_ff @(posedge clk) begin
    if (bk_we) begin
      key_m[bk_wa] <= q_item.addr + {16'd0, q_item.port};
      wt_m[bk_wa]  <= q_item.weight;
      ov_m[bk_wa]  <= q_item.overloaded;
    end
    key_q <= key_m[bk_ra];
    wt_q  <= wt_m[bk_ra];
    ov_q  <= ov_m[bk_ra];
  end

  // probe state per backend
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_m[i_r] <= pos_wd;
    end
    if (str_we) begin
      str_m[i_r] <= str_wd;
    end
    pos_q <= pos_m[i_r];
    str_q <= str_m[i_r];
  end

  // bucket table: {valid, owner}
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_m[tbl_wa] <= tbl_wd;
    end
    tbl_q <= tbl_m[tbl_ra];
  end

  assign st.init_busy   = init_r;
  assign out_valid       = out_valid_r;
  assign out_op_done     = out_op_r;
  assign out_found       = out_found_r;
  assign out_backend     = out_be_r;
  assign out_table_empty = out_empty_r;

endmodule

FILE: sv/maglev_lookup_table_scheduler.sv
// ----------------------------------------------------------------------------
// maglev_lookup_table_scheduler
// Maglev consistent-hash table: backend loads, weighted rebuild, flow lookup.
// ----------------------------------------------------------------------------
// Usage
//   Input words (in_*) carry an op: load a backend slot, rebuild the table,
//   or look up a flow. Each op 0..2 returns exactly one result word (out_*);
//   op 3 is dropped with no result. Both channels use valid/stall.
//   cfg_dest_count sets how many slots a rebuild walks; write it only while
//   the block is idle. cfg_ready is always high.
// Operation (one word executed at a time)
//   load    : writes the slot and registers the result as the word is popped.
//   lookup  : queue pop, hash multiply, pipelined constant remainder and two
//             table reads, in that order. The next word is popped only once
//             the lookup has finished.
//   rebuild : per backend slot a key read and two hash+remainder passes, then
//             a clearing sweep over all TABLE_SIZE buckets, then the fill in
//             backend turns (a slot read each) and probes (a table read each).
// Reset
//   After rst_n the table is cleared in a sweep over all buckets; in_stall
//   stays high until the sweep ends.
// Back-pressure
//   A two-word queue lets the input keep filling while the back end works;
//   a held result stays stable in the output register under out_stall.
// ----------------------------------------------------------------------------
module maglev_lookup_table_scheduler import mlv_pkg::*; #(
  parameter int TABLE_SIZE   = 65537,
  parameter int MAX_BACKENDS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [5:0]  in_slot,
  input  logic [31:0] in_addr,
  input  logic [15:0] in_port,
  input  logic [15:0] in_weight,
  input  logic        in_overloaded,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_op_done,
  output logic        out_found,
  output logic [5:0]  out_backend,
  output logic        out_table_empty,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_dest_count
);

  logic [6:0]  dest_r, dest_nxt;
  logic        q_valid, q_pop;
  mlv_item_t   q_item;
  mlv_status_t st;

  // config register
  assign cfg_ready = 1'b1;
  assign dest_nxt  = (cfg_valid && cfg_ready) ? cfg_dest_count : dest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_r <= 7'd0;
    end else begin
      dest_r <= dest_nxt;
    end
  end

  mlv_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_slot       (in_slot),
    .in_addr       (in_addr),
    .in_port       (in_port),
    .in_weight     (in_weight),
    .in_overloaded (in_overloaded),
    .st            (st),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  mlv_back #(
    .TABLE_SIZE   (TABLE_SIZE),
    .MAX_BACKENDS (MAX_BACKENDS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .dest_count      (dest_r),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .st              (st),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_op_done     (out_op_done),
    .out_found       (out_found),
    .out_backend     (out_backend),
    .out_table_empty (out_table_empty)
  );

endmodule

FILE: sv/mlv_checker.sv
// ----------------------------------------------------------------------------
// mlv_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module mlv_checker import mlv_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_op_done,
  input logic       out_found,
  input logic [5:0] out_backend,
  input logic       out_table_empty
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");

  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_backend) && $stable(out_op_done))
    else $error("stalled result changed");

  a_found_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_op_done == OP_LOOKUP)
    else $error("found set on a non-lookup result");

  a_empty_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_empty |-> out_op_done == OP_REBUILD)
    else $error("table_empty set on a non-rebuild result");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_backend == 6'd0)
    else $error("backend nonzero on a miss");

endmodule

bind maglev_lookup_table_scheduler mlv_checker u_chk (.*);

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Maglev lookup table scheduler. A directed table
// covers the empty table, extreme field values and the dropped op code. It is
// followed by phases of random loads and lookups, each with its own dest_count
// and a rebuild. Directed results are checked against their rows, the rest
// against an in-bench table model. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top import mlv_pkg::*; ();

  localparam int unsigned NBUCKET = 65537;
  localparam int unsigned NSLOT   = 64;

  // one result word as seen on out_*
  typedef struct packed {
    logic [1:0] op;
    logic       found;
    logic [5:0] backend;
    logic       empty;
  } res_word_t;

  typedef struct packed {
    mlv_item_t w;
    logic      typed;   // expected word written out below
    res_word_t r;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op = OP_LOAD;
  logic [5:0]  in_slot = '0;
  logic [31:0] in_addr = '0;
  logic [15:0] in_port = '0;
  logic [15:0] in_weight = '0;
  logic        in_overloaded = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [1:0]  out_op_done;
  logic        out_found;
  logic [5:0]  out_backend;
  logic        out_table_empty;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_dest_count = '0;

  maglev_lookup_table_scheduler i_dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_op, .in_slot, .in_addr, .in_port, .in_weight,
    .in_overloaded,
    .out_valid, .out_stall, .out_op_done, .out_found, .out_backend,
    .out_table_empty,
    .cfg_valid, .cfg_ready, .cfg_dest_count
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Table model: own copy of bucket map, backend slots and dest_count
  // --------------------------------------------------------------------------
  bit          bkt_taken [NBUCKET];
  logic [6:0]  bkt_owner [NBUCKET];   // bit 6 marks an assigned bucket
  bit   [31:0] slot_key  [NSLOT];
  bit   [15:0] slot_wt   [NSLOT];
  bit          slot_ovl  [NSLOT];
  int unsigned slot_pos  [NSLOT];
  int unsigned slot_step [NSLOT];
  int unsigned dest_cnt = 0;

  res_word_t owed_words[$];   // results still to come, oldest first
  int        errors = 0;

  // receiver controls
  bit idle_on   = 1'b0;
  bit long_hold = 1'b0;

  function automatic bit [31:0] mix(bit [31:0] x);
    return x * HASH_MULT;   // product kept mod 2^32
  endfunction

  function automatic void clear_table();
    bkt_taken = '{default: 1'b0};
    bkt_owner = '{default: 7'd0};
  endfunction

  // weighted round-robin fill; returns 1 when the table is left empty
  function automatic bit rebuild_table();
    int unsigned cnt, i, n, run, w, c, k;
    bit any, got;
    cnt = (dest_cnt > NSLOT) ? NSLOT : dest_cnt;
    any = 1'b0;
    if (cnt == 0) begin
      clear_table();
      return 1'b1;
    end
    for (i = 0; i < cnt; i++) begin
      if (slot_wt[i] != 0) any = 1'b1;
      slot_pos[i]  = mix(slot_key[i]) % NBUCKET;
      slot_step[i] = mix(slot_key[i] + 32'd1) % (NBUCKET - 1) + 1;
    end
    clear_table();
    if (!any) return 1'b1;
    i = 0; n = 0; run = 0;
    while (n < NBUCKET) begin
      w = 32'(slot_wt[i]);
      if (w > 0) begin
        got = 1'b0;
        c = 0;
        for (k = 0; k < NBUCKET; k++) begin
          c = slot_pos[i];
          slot_pos[i] = (c + slot_step[i]) % NBUCKET;
          if (!bkt_taken[c]) begin
            got = 1'b1;
            break;
          end
        end
        if (!got) break;
        bkt_taken[c] = 1'b1;
        bkt_owner[c] = {1'b1, i[5:0]};
        n++;
        if (n == NBUCKET) break;
        run++;
        if (run >= w) begin
          run = 0;
          i = (i + 1) % cnt;
        end
      end else begin
        run = 0;
        i = (i + 1) % cnt;
      end
    end
    return 1'b0;
  endfunction

  // applies one accepted word; returns 0 when no result is due
  function automatic bit maglev_predict(mlv_item_t w, output res_word_t r);
    bit [31:0]   sum;
    int unsigned b;
    r = '0;
    r.op = w.op;
    sum = w.addr + 32'(w.port);
    case (w.op)
      OP_LOAD: begin
        slot_key[w.slot] = sum;
        slot_wt[w.slot]  = w.weight;
        slot_ovl[w.slot] = w.overloaded;
      end
      OP_REBUILD: begin
        r.empty = rebuild_table();
      end
      OP_LOOKUP: begin
        b = mix(sum) % NBUCKET;
        if (bkt_owner[b][6] && !slot_ovl[bkt_owner[b][5:0]]) begin
          r.found   = 1'b1;
          r.backend = bkt_owner[b][5:0];
        end
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Input side: called at a falling edge, returns at a falling edge
  // --------------------------------------------------------------------------
  task automatic offer_word(mlv_item_t w, bit typed, res_word_t typed_r);
    int        gap;
    res_word_t r;
    gap = idle_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= w.op;
    in_slot       <= w.slot;
    in_addr       <= w.addr;
    in_port       <= w.port;
    in_weight     <= w.weight;
    in_overloaded <= w.overloaded;
    do @(posedge clk); while (in_stall);
    // word taken at this edge
    if (maglev_predict(w, r)) owed_words.push_back(typed ? typed_r : r);
    @(negedge clk);
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (owed_words.size() != 0) @(negedge clk);
    // a dropped op 3 is never queued; the wait is a settling margin
    repeat (100) @(negedge clk);
  endtask

  task automatic write_dest_count(logic [6:0] v);
    cfg_valid      <= 1'b1;
    cfg_dest_count <= v;
    do @(posedge clk); while (!cfg_ready);
    dest_cnt = 32'(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic mlv_item_t rand_load(bit [5:0] slot);
    mlv_item_t w;
    w.op         = OP_LOAD;
    w.slot       = slot;
    w.addr       = $urandom;
    w.port       = 16'($urandom);
    case ($urandom_range(0, 9))
      0:       w.weight = 16'd0;
      1, 2:    w.weight = 16'($urandom);
      default: w.weight = 16'($urandom_range(1, 4));
    endcase
    w.overloaded = ($urandom_range(0, 4) == 0);
    return w;
  endfunction

  function automatic mlv_item_t rand_word();
    mlv_item_t w;
    int        pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) return rand_load(6'($urandom));
    w.op         = (pick < 97) ? OP_LOOKUP : OP_NONE;
    w.slot       = 6'($urandom);
    w.addr       = $urandom;
    w.port       = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
    w.weight     = 16'($urandom);
    w.overloaded = 1'($urandom);
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Output side: draws a stall per word, or one long hold when asked
  // --------------------------------------------------------------------------
  initial begin : receiver
    int        hold;
    res_word_t exp_r, got_r;
    @(negedge clk);
    forever begin
      if (long_hold) begin
        hold = 400;
        long_hold = 1'b0;
      end else begin
        hold = idle_on ? $urandom_range(0, 18) : 0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got_r = '{out_op_done, out_found, out_backend, out_table_empty};
      if (owed_words.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing owed: %p", $time, got_r);
      end else begin
        exp_r = owed_words.pop_front();
        if (got_r.op !== exp_r.op) begin
          errors++;
          $display("%0t: op_done exp %0d got %0d", $time, exp_r.op, got_r.op);
        end
        if (got_r.found !== exp_r.found) begin
          errors++;
          $display("%0t: found exp %0d got %0d", $time, exp_r.found, got_r.found);
        end
        if (got_r.backend !== exp_r.backend) begin
          errors++;
          $display("%0t: backend exp %0d got %0d", $time, exp_r.backend,
                   got_r.backend);
        end
        if (got_r.empty !== exp_r.empty) begin
          errors++;
          $display("%0t: table_empty exp %0d got %0d", $time, exp_r.empty,
                   got_r.empty);
        end
      end
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // directed rows, run with dest_count still 0 from reset
  dir_row_t dir_rows[10] = '{
    // lookups on the freshly cleared table miss
    '{'{OP_LOOKUP, 6'd0, 32'h0, 16'h0, 16'h0, 1'b0}, 1'b1,
      '{OP_LOOKUP, 1'b0, 6'd0, 1'b0}},
    '{'{OP_LOOKUP, 6'd63, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b1,
      '{OP_LOOKUP, 1'b0, 6'd0, 1'b0}},
    // no backends in use: rebuild empties
    '{'{OP_REBUILD, 6'd0, 32'h0, 16'h0, 16'h0, 1'b0}, 1'b1,
      '{OP_REBUILD, 1'b0, 6'd0, 1'b1}},
    '{'{OP_LOAD, 6'd0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b1,
      '{OP_LOAD, 1'b0, 6'd0, 1'b0}},
    '{'{OP_LOAD, 6'd63, 32'h0, 16'h0, 16'h0, 1'b0}, 1'b1,
      '{OP_LOAD, 1'b0, 6'd0, 1'b0}},
    '{'{OP_LOAD, 6'd1, 32'h8000_0001, 16'h8000, 16'h1, 1'b0}, 1'b1,
      '{OP_LOAD, 1'b0, 6'd0, 1'b0}},
    // unused op code: dropped, nothing owed
    '{'{OP_NONE, 6'd5, 32'h1234_5678, 16'h1, 16'h2, 1'b0}, 1'b0, '0},
    '{'{OP_LOOKUP, 6'd0, 32'hC0A8_0001, 16'd80, 16'h0, 1'b0}, 1'b1,
      '{OP_LOOKUP, 1'b0, 6'd0, 1'b0}},
    '{'{OP_REBUILD, 6'd63, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b1,
      '{OP_REBUILD, 1'b0, 6'd0, 1'b1}},
    '{'{OP_NONE, 6'd63, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b0, '0}
  };

  // dest_count per phase; 127 saturates to all 64 slots
  logic [6:0] phase_dest[8] = '{7'd1, 7'd2, 7'd127, 7'd0, 7'd3, 7'd2, 7'd5, 7'd1};

  initial begin : stimulus
    mlv_item_t w;
    int        rb_at;
    clear_table();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[j]) offer_word(dir_rows[j].w, dir_rows[j].typed, dir_rows[j].r);

    // give every slot a backend so that no rebuild reads an unloaded one
    idle_on = 1'b1;
    for (int s = 0; s < NSLOT; s++) offer_word(rand_load(6'(s)), 1'b0, '0);

    for (int p = 0; p < 8; p++) begin
      drain_and_settle();
      write_dest_count(phase_dest[p]);
      idle_on = (p % 3 != 0);
      if (p == 1) begin
        // all in-use weights zero: rebuild must empty, then refill
        w = rand_load(6'd0);  w.weight = 16'd0; offer_word(w, 1'b0, '0);
        w = rand_load(6'd1);  w.weight = 16'd0; offer_word(w, 1'b0, '0);
        w = '0; w.op = OP_REBUILD; offer_word(w, 1'b0, '0);
        w = rand_load(6'd0);  w.weight = 16'd3; offer_word(w, 1'b0, '0);
      end
      if (p == 4) long_hold = 1'b1;   // receiver sits while lookups pile up
      rb_at = $urandom_range(0, 15);
      for (int k = 0; k < 140; k++) begin
        if (k == rb_at) begin
          w = rand_word();
          w.op = OP_REBUILD;
        end else begin
          w = rand_word();
        end
        offer_word(w, 1'b0, '0);
      end
    end

    // end of run: every owed word back, then let the pipe settle
    in_valid <= 1'b0;
    while (owed_words.size() != 0) @(negedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("maglev_lookup_table_scheduler regression: pass");
    end else begin
      $display("maglev_lookup_table_scheduler regression: fail");
    end
    $finish;
  end

  // rebuilds over the full table dominate; this is many times the slowest run
  initial begin : watchdog
    #600_000_000;
    $display("maglev_lookup_table_scheduler regression: fail");
    $finish;
  end

endmodule
